// ===== hdl/bda_pkg.sv =====
// Shared types and constants for the buddy allocator.
`default_nettype none

package bda_pkg;

    localparam int REQ_W      = 12;
    localparam int OFF_W      = 9;
    localparam int RP_W       = REQ_W + 1;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;
    localparam int M_PAD_W    = M_TDATA_W - OFF_W - 1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_ACHK,
        OP_DESC,
        OP_CLIMB,
        OP_ASC,
        OP_FIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   load;
    } dp_ctrl_t;

    typedef struct packed {
        logic clr_last;
        logic fail;
        logic more;
        logic nonzero;
        logic idx_root;
        logic parent_root;
        logic is_free;
        logic off_bad;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/buddy_allocator_unit.sv =====
// Binary buddy allocator top level: request/result streams around controller and datapath.
//
// Requests enter on s_axis_*: tuser selects allocate or free, tdata carries the
// unit count and the offset to release. Each request gives exactly one result
// on m_axis_*: a status bit and the allocated block offset.
// After reset the tree memory is initialised by a sweep that writes every tree
// node; s_axis_tready stays low until it ends.
// One request is in flight at a time; the tree memory has one read and one
// write port, and the tree is walked level by level.
// Allocate: accept, root check, descent level by level, an update of each
// ancestor, a finish step; a failure, or a request the size of the whole
// tree, goes from the root check straight to the finish step.
// Free: accept, climb to the used node, an update of each ancestor, a finish
// step.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver stalls, the next result holds in its finish state
// until the register drains.
`default_nettype none

module buddy_allocator_unit #(
    parameter int TOTAL_UNITS = 512
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [11:0] request_units, [20:12] release_offset, [23:21] zero
    input  wire logic [bda_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [0] cmd
    input  wire logic [0:0]                       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [0] status, [9:1] block_offset, [15:10] zero
    output logic [bda_pkg::M_TDATA_W-1:0]         m_axis_tdata
);

    bda_pkg::dp_ctrl_t ctrl;
    bda_pkg::dp_stat_t stat;
    logic                        out_status;
    logic [bda_pkg::OFF_W-1:0]   out_offset;

    bda_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    bda_datapath #(
        .TOTAL_UNITS (TOTAL_UNITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .in_cmd     (s_axis_tuser[0]),
        .in_req     (s_axis_tdata[bda_pkg::REQ_W-1:0]),
        .in_off     (s_axis_tdata[bda_pkg::REQ_W +: bda_pkg::OFF_W]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (out_status),
        .out_offset (out_offset)
    );

    assign m_axis_tdata = {{bda_pkg::M_PAD_W{1'b0}}, out_offset, out_status};

endmodule

`default_nettype wire

// ===== hdl/bda_datapath.sv =====
// Tree memory, index/size registers, merge logic and output register.
`default_nettype none

module bda_datapath #(
    parameter int TOTAL_UNITS = 512
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire bda_pkg::dp_ctrl_t      ctrl,
    output bda_pkg::dp_stat_t           stat,
    input  wire logic                   in_cmd,
    input  wire logic [bda_pkg::REQ_W-1:0] in_req,
    input  wire logic [bda_pkg::OFF_W-1:0] in_off,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        out_status,
    output logic [bda_pkg::OFF_W-1:0]   out_offset
);

    localparam int DEPTH     = 2 * TOTAL_UNITS;
    localparam int NODE_LAST = DEPTH - 1;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int VAL_W     = $clog2(TOTAL_UNITS) + 1;
    localparam int POS_W     = $clog2(TOTAL_UNITS);
    localparam int CMP_W     = (VAL_W > bda_pkg::RP_W) ? VAL_W : bda_pkg::RP_W;
    localparam int WIDE_W    = IDX_W + bda_pkg::OFF_W;
    localparam int PW_W      = POS_W + bda_pkg::OFF_W;

    logic [VAL_W-1:0] tree_mem [DEPTH];

    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [VAL_W-1:0]         size_reg, size_next;
    logic [VAL_W-1:0]         cur_reg, cur_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [bda_pkg::RP_W-1:0] req_reg, req_next;
    logic                     free_reg, free_next;
    logic                     fail_reg, fail_next;
    logic [VAL_W-1:0]         rd_data_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_status_reg, out_status_next;
    logic [bda_pkg::OFF_W-1:0] out_offset_reg, out_offset_next;

    logic [IDX_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [VAL_W-1:0]         wr_data;

    logic [bda_pkg::REQ_W-1:0] req_m1;
    logic [bda_pkg::RP_W-1:0]  req_pow;
    logic [WIDE_W-1:0]         off_wide;
    logic [WIDE_W-1:0]         leaf_wide;
    logic [IDX_W-1:0]          leaf;
    logic                      in_free;

    logic [CMP_W-1:0] rd_cmp, req_cmp, size_cmp, half_cmp;
    logic [IDX_W-1:0] left, choose, parent, sib;
    logic [VAL_W-1:0] half, psize, bigger, merged;
    logic [VAL_W:0]   pair_sum;
    logic [PW_W-1:0]  pos_wide;
    logic             fail, more_achk, more_desc, nonzero, idx_root, parent_root;
    logic             clr_last, clr_shrink, out_busy;

    // request rounded up to a power of two, zero taken as one
    always_comb
    begin
        req_m1  = (in_req == '0) ? '0 : in_req - bda_pkg::REQ_W'(1);
        req_pow = bda_pkg::RP_W'(1);
        for (int i = 0; i < bda_pkg::REQ_W; i++)
        begin
            if (req_m1[i])
                req_pow = bda_pkg::RP_W'(2) << i;
        end
    end

    assign in_free   = (in_cmd == bda_pkg::CMD_FREE);
    assign off_wide  = WIDE_W'(in_off);
    assign leaf_wide = WIDE_W'(TOTAL_UNITS) + off_wide;
    assign leaf      = leaf_wide[IDX_W-1:0];

    assign half      = size_reg >> 1;
    assign psize     = size_reg << 1;
    assign rd_cmp    = CMP_W'(rd_data_reg);
    assign req_cmp   = CMP_W'(req_reg);
    assign size_cmp  = CMP_W'(size_reg);
    assign half_cmp  = CMP_W'(half);
    assign fail      = rd_cmp < req_cmp;
    assign more_achk = size_cmp > req_cmp;
    assign more_desc = half_cmp > req_cmp;
    assign nonzero   = (rd_data_reg != '0);

    assign left      = idx_reg << 1;
    assign choose    = (rd_cmp >= req_cmp) ? left : (left | IDX_W'(1));
    assign parent    = idx_reg >> 1;
    assign sib       = idx_reg ^ IDX_W'(1);
    assign idx_root  = (idx_reg == IDX_W'(1));
    assign parent_root = (parent == IDX_W'(1));

    assign bigger    = (cur_reg > rd_data_reg) ? cur_reg : rd_data_reg;
    assign pair_sum  = {1'b0, cur_reg} + {1'b0, rd_data_reg};
    assign merged    = (free_reg && pair_sum == {1'b0, psize}) ? psize : bigger;

    assign clr_last   = (idx_reg == IDX_W'(NODE_LAST));
    assign clr_shrink = ((idx_reg & (idx_reg + IDX_W'(1))) == '0);
    assign out_busy   = out_valid_reg & ~out_ready;
    assign pos_wide   = PW_W'(pos_reg);

    always_comb
    begin
        stat.clr_last    = clr_last;
        stat.fail        = fail;
        stat.more        = (ctrl.op == bda_pkg::OP_DESC) ? more_desc : more_achk;
        stat.nonzero     = nonzero;
        stat.idx_root    = idx_root;
        stat.parent_root = parent_root;
        stat.is_free     = in_free;
        stat.off_bad     = (off_wide >= WIDE_W'(TOTAL_UNITS));
        stat.out_busy    = out_busy;
    end

    always_comb
    begin
        idx_next        = idx_reg;
        size_next       = size_reg;
        cur_next        = cur_reg;
        pos_next        = pos_reg;
        req_next        = req_reg;
        free_next       = free_reg;
        fail_next       = fail_reg;
        out_status_next = out_status_reg;
        out_offset_next = out_offset_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = size_reg;

        case (ctrl.op)
            bda_pkg::OP_CLEAR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
                if (clr_shrink)
                    size_next = half;
            end
            bda_pkg::OP_IDLE:
            begin
                rd_addr = in_free ? leaf : IDX_W'(1);
                if (ctrl.load)
                begin
                    free_next = in_free;
                    req_next  = req_pow;
                    fail_next = 1'b0;
                    pos_next  = '0;
                    idx_next  = in_free ? leaf : IDX_W'(1);
                    size_next = in_free ? VAL_W'(1) : VAL_W'(TOTAL_UNITS);
                end
            end
            bda_pkg::OP_ACHK:
            begin
                fail_next = fail;
                if (!fail)
                begin
                    if (more_achk)
                        rd_addr = left;
                    else
                    begin
                        wr_en    = 1'b1;
                        wr_data  = '0;
                        cur_next = '0;
                        rd_addr  = sib;
                    end
                end
            end
            bda_pkg::OP_DESC:
            begin
                idx_next  = choose;
                size_next = half;
                if (choose[0])
                    pos_next = pos_reg + POS_W'(half);
                if (more_desc)
                    rd_addr = choose << 1;
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = choose;
                    wr_data  = '0;
                    cur_next = '0;
                    rd_addr  = choose ^ IDX_W'(1);
                end
            end
            bda_pkg::OP_CLIMB:
            begin
                if (nonzero)
                begin
                    if (!idx_root)
                    begin
                        idx_next  = parent;
                        size_next = psize;
                        rd_addr   = parent;
                    end
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_data  = size_reg;
                    cur_next = size_reg;
                    rd_addr  = sib;
                end
            end
            bda_pkg::OP_ASC:
            begin
                wr_en     = 1'b1;
                wr_addr   = parent;
                wr_data   = merged;
                idx_next  = parent;
                size_next = psize;
                cur_next  = merged;
                rd_addr   = parent ^ IDX_W'(1);
            end
            bda_pkg::OP_FIN:
            begin
                if (!out_busy)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = fail_reg ? bda_pkg::STATUS_FAIL : bda_pkg::STATUS_OK;
                    out_offset_next = free_reg ? '0 : pos_wide[bda_pkg::OFF_W-1:0];
                end
            end
            default:
            begin
                rd_addr = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            tree_mem[wr_addr] <= wr_data;
        rd_data_reg <= tree_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= IDX_W'(1);
            size_reg      <= VAL_W'(TOTAL_UNITS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        pos_reg        <= pos_next;
        req_reg        <= req_next;
        free_reg       <= free_next;
        fail_reg       <= fail_next;
        out_status_reg <= out_status_next;
        out_offset_reg <= out_offset_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_offset = out_offset_reg;

endmodule

`default_nettype wire

// ===== hdl/bda_controller.sv =====
// Sequencer for clearing, allocate descent, free climb and ancestor update.
`default_nettype none

module bda_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire bda_pkg::dp_stat_t stat,
    output bda_pkg::dp_ctrl_t      ctrl
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACHK,
        ST_DESC,
        ST_CLIMB,
        ST_ASC,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl.load  = 1'b0;
        ctrl.op    = bda_pkg::OP_IDLE;
        case (state_reg)
            ST_CLEAR:
            begin
                ctrl.op = bda_pkg::OP_CLEAR;
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                ctrl.op = bda_pkg::OP_IDLE;
                if (in_valid)
                begin
                    ctrl.load = 1'b1;
                    if (!stat.is_free)
                        state_next = ST_ACHK;
                    else if (stat.off_bad)
                        state_next = ST_FIN;
                    else
                        state_next = ST_CLIMB;
                end
            end
            ST_ACHK:
            begin
                ctrl.op = bda_pkg::OP_ACHK;
                if (stat.fail)
                    state_next = ST_FIN;
                else if (stat.more)
                    state_next = ST_DESC;
                else if (stat.idx_root)
                    state_next = ST_FIN;
                else
                    state_next = ST_ASC;
            end
            ST_DESC:
            begin
                ctrl.op = bda_pkg::OP_DESC;
                if (!stat.more)
                    state_next = ST_ASC;
            end
            ST_CLIMB:
            begin
                ctrl.op = bda_pkg::OP_CLIMB;
                if (stat.idx_root)
                    state_next = ST_FIN;
                else if (!stat.nonzero)
                    state_next = ST_ASC;
            end
            ST_ASC:
            begin
                ctrl.op = bda_pkg::OP_ASC;
                if (stat.parent_root)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                ctrl.op = bda_pkg::OP_FIN;
                if (!stat.out_busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== bench/buddy_allocator_unit_checker.sv =====
// Buddy allocator checker: shadow longest-free tree, expected replies and comparison.
`timescale 1ns / 1ps

module buddy_allocator_unit_checker #(
    parameter int TOTAL_UNITS = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    // [11:0] request_units, [20:12] release_offset, [23:21] zero
    input  logic [bda_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] cmd
    input  logic [0:0]                    s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] status, [9:1] block_offset, [15:10] zero
    input  logic [bda_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output int                            pending_count,
    output int                            fail_count
);

    localparam int NODE_COUNT = 2 * TOTAL_UNITS - 1;
    localparam int TREE_W     = $clog2(TOTAL_UNITS) + 1;

    typedef struct packed {
        logic                      status;
        logic [bda_pkg::OFF_W-1:0] block_offset;
    } alloc_reply_t;

    logic [TREE_W-1:0] free_tree [NODE_COUNT];
    alloc_reply_t      expected_replies [$];
    int                errors;

    function automatic alloc_reply_t apply_request(input logic                      cmd,
                                                   input logic [bda_pkg::REQ_W-1:0] units,
                                                   input logic [bda_pkg::OFF_W-1:0] offset);
        alloc_reply_t             reply;
        logic [bda_pkg::RP_W-1:0] want;
        int                       idx;
        int                       span;
        int                       lsz;
        int                       rsz;
        reply.status       = bda_pkg::STATUS_OK;
        reply.block_offset = '0;
        if (cmd == bda_pkg::CMD_ALLOC)
        begin
            want = 1;
            while (want < units)
                want = want << 1;
            if (free_tree[0] < want)
            begin
                reply.status = bda_pkg::STATUS_FAIL;
                return reply;
            end
            idx  = 0;
            span = TOTAL_UNITS;
            while (span > want && 2 * idx + 1 < NODE_COUNT)
            begin
                idx  = (free_tree[2 * idx + 1] >= want) ? 2 * idx + 1 : 2 * idx + 2;
                span = span / 2;
            end
            free_tree[idx]     = '0;
            reply.block_offset = bda_pkg::OFF_W'((idx + 1) * span - TOTAL_UNITS);
            while (idx != 0)
            begin
                idx = (idx + 1) / 2 - 1;
                lsz = free_tree[2 * idx + 1];
                rsz = free_tree[2 * idx + 2];
                free_tree[idx] = TREE_W'((lsz > rsz) ? lsz : rsz);
            end
        end
        else
        begin
            if (int'(offset) >= TOTAL_UNITS)
                return reply;
            idx  = int'(offset) + TOTAL_UNITS - 1;
            span = 1;
            while (free_tree[idx] != 0)
            begin
                span = span * 2;
                if (idx == 0)
                    return reply;
                idx = (idx + 1) / 2 - 1;
            end
            free_tree[idx] = TREE_W'(span);
            // merge buddies back up to the root
            while (idx != 0)
            begin
                idx  = (idx + 1) / 2 - 1;
                span = span * 2;
                lsz  = free_tree[2 * idx + 1];
                rsz  = free_tree[2 * idx + 2];
                free_tree[idx] = TREE_W'((lsz + rsz == span) ? span :
                                         ((lsz > rsz) ? lsz : rsz));
            end
        end
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int           span;
        alloc_reply_t exp_reply;
        if (!rst_n)
        begin
            span = 2 * TOTAL_UNITS;
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                if (((i + 1) & i) == 0)
                    span = span / 2;
                free_tree[i] = TREE_W'(span);
            end
            expected_replies.delete();
            errors        = 0;
            pending_count <= 0;
            fail_count    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("unexpected result: tdata %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    exp_reply = expected_replies.pop_front();
                    if (m_axis_tdata[0] !== exp_reply.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               exp_reply.status, m_axis_tdata[0]);
                        errors++;
                    end
                    if (m_axis_tdata[bda_pkg::OFF_W:1] !== exp_reply.block_offset)
                    begin
                        $error("block_offset: expected %0d, actual %0d",
                               exp_reply.block_offset, m_axis_tdata[bda_pkg::OFF_W:1]);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_replies.push_back(
                    apply_request(s_axis_tuser[0],
                                  s_axis_tdata[bda_pkg::REQ_W-1:0],
                                  s_axis_tdata[bda_pkg::REQ_W +: bda_pkg::OFF_W]));
            pending_count <= expected_replies.size();
            fail_count    <= errors;
        end
    end

endmodule

// ===== bench/buddy_allocator_unit_tb.sv =====
// Buddy allocator testbench top: clock, reset, request stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module buddy_allocator_unit_tb;
    import bda_pkg::*;

    localparam int TOTAL_UNITS    = 512;
    localparam int RANDOM_ITEMS   = 900;
    localparam int QUIET_TAIL     = 150;
    localparam int LONG_STALL     = 200;
    localparam int STALL_AT       = 300;
    localparam int TAIL_CYCLES    = 50;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LIVE_MAX       = 64;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int               fail_count;
    int               pending_count;
    int               sent_count;
    int               quiet_cycles;
    bit               idle_on;
    bit               long_stall_done;
    logic [OFF_W-1:0] live_blocks [$];

    buddy_allocator_unit #(
        .TOTAL_UNITS(TOTAL_UNITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    buddy_allocator_unit_checker #(
        .TOTAL_UNITS(TOTAL_UNITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .pending_count(pending_count),
        .fail_count   (fail_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_request(input logic             cmd,
                                input logic [REQ_W-1:0] units,
                                input logic [OFF_W-1:0] offset);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(S_TDATA_W - REQ_W - OFF_W){1'b0}}, offset, units};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_count++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_random_request(input int n);
        int               roll;
        int               pick;
        logic             cmd;
        logic [REQ_W-1:0] units;
        logic [OFF_W-1:0] offset;
        units  = REQ_W'($urandom);
        offset = OFF_W'($urandom);
        // alternate allocate-heavy and free-heavy stretches
        if ($urandom_range(0, 99) < (((n / 60) % 2 == 0) ? 75 : 30)) begin
            cmd  = CMD_ALLOC;
            roll = $urandom_range(0, 99);
            if (roll < 50)
                units = REQ_W'($urandom_range(0, 8));
            else if (roll < 80)
                units = REQ_W'($urandom_range(9, 64));
            else if (roll < 93)
                units = REQ_W'($urandom_range(65, 512));
            else
                units = REQ_W'($urandom_range(513, 4095));
        end
        else begin
            cmd = CMD_FREE;
            if (live_blocks.size() != 0 && $urandom_range(0, 9) < 8) begin
                pick   = $urandom_range(0, live_blocks.size() - 1);
                offset = live_blocks[pick];
                live_blocks.delete(pick);
                if ($urandom_range(0, 5) == 0)
                    offset = offset + OFF_W'($urandom_range(1, 3));
            end
        end
        send_request(cmd, units, offset);
    endtask

    // offsets handed out, used to aim frees at live blocks
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready && m_axis_tdata[0] == STATUS_OK
            && m_axis_tdata[OFF_W:1] != '0 && live_blocks.size() < LIVE_MAX)
            live_blocks.push_back(m_axis_tdata[OFF_W:1]);
    end

    initial
    begin
        m_axis_tready   = 1'b0;
        long_stall_done = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (!long_stall_done && sent_count >= STALL_AT) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                long_stall_done = 1'b1;
                m_axis_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("buddy_allocator_unit_tb failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_ALLOC;
        sent_count    = 0;
        idle_on       = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_request(CMD_ALLOC, 12'd0,    9'd0);
        send_request(CMD_ALLOC, 12'd1,    9'd511);
        send_request(CMD_ALLOC, 12'd3,    9'd0);
        send_request(CMD_ALLOC, 12'd8,    9'd0);
        send_request(CMD_ALLOC, 12'd4095, 9'd0);
        send_request(CMD_ALLOC, 12'd512,  9'd0);
        // free inside a larger block releases all of it
        send_request(CMD_FREE,  12'd4095, 9'd11);
        // nothing used on the path
        send_request(CMD_FREE,  12'd0,    9'd300);
        send_request(CMD_FREE,  12'd0,    9'd511);
        send_request(CMD_FREE,  12'd0,    9'd0);
        send_request(CMD_FREE,  12'd0,    9'd1);
        send_request(CMD_FREE,  12'd0,    9'd4);
        send_request(CMD_ALLOC, 12'd512,  9'd0);
        send_request(CMD_ALLOC, 12'd0,    9'd0);
        send_request(CMD_FREE,  12'd0,    9'd511);
        send_request(CMD_ALLOC, 12'd256,  9'd0);
        send_request(CMD_ALLOC, 12'd256,  9'd0);
        send_request(CMD_ALLOC, 12'd1,    9'd0);
        send_request(CMD_FREE,  12'd0,    9'd256);
        send_request(CMD_FREE,  12'd0,    9'd0);
        send_request(CMD_ALLOC, 12'd2048, 9'd0);
        send_request(CMD_ALLOC, 12'd513,  9'd0);
        send_request(CMD_ALLOC, 12'd511,  9'd0);
        send_request(CMD_FREE,  12'd0,    9'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = !((n >= 450 && n < 550) || n >= RANDOM_ITEMS - QUIET_TAIL);
            send_random_request(n);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("buddy_allocator_unit_tb passed");
        else
            $display("buddy_allocator_unit_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bda_pkg.sv
hdl/bda_datapath.sv
hdl/bda_controller.sv
hdl/buddy_allocator_unit.sv
bench/buddy_allocator_unit_checker.sv
bench/buddy_allocator_unit_tb.sv
